// ===== hdl/hrlc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrlc_pkg
// Shared types, character codes and defaults of the request line checker.
// ----------------------------------------------------------------------------
package hrlc_pkg;

  localparam int MAX_METHOD_DEF  = 16;
  localparam int MAX_PATH_DEF    = 256;
  localparam int MAX_VERSION_DEF = 16;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;

  typedef enum logic [1:0] {
    PH_METHOD  = 2'd0,
    PH_PATH    = 2'd1,
    PH_VERSION = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    TAG_METHOD  = 3'd0,
    TAG_PATH    = 3'd1,
    TAG_VERSION = 3'd2,
    TAG_SEP     = 3'd3,
    TAG_IGNORED = 3'd4
  } tag_t;

  // "HTTP/1." prefix of the version field
  function automatic logic [7:0] ver_prefix(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2F;
      3'd5:    c = 8'h31;
      3'd6:    c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/http_request_line_check_core.sv =====
// ----------------------------------------------------------------------------
// http_request_line_check_core
// Byte-serial check of an HTTP/1.x request line with per-byte tagging.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready) carries one raw request byte per word,
//   with buffer_end set on the last byte of the buffer
//   output channel (out_valid / out_ready) returns one result word per input
//   word: byte tag, held cr flag, verdict and running field lengths
//   the result word is registered and valid in the cycle after its byte
//   throughput: one word per cycle while out_ready is high; the parse state is
//   updated in the same cycle the byte is taken, so consecutive bytes never wait on each other
//   stall: while out_ready is low and a result is held, in_ready is low; a
//   taken result frees the register in the same cycle for the next byte
//   reset: parse state returns to the method phase, the result register is
//   emptied; buffer_end also restarts the parse state after its byte
// ----------------------------------------------------------------------------
module http_request_line_check_core
  import hrlc_pkg::*;
#(
  parameter int MAX_METHOD  = MAX_METHOD_DEF,
  parameter int MAX_PATH    = MAX_PATH_DEF,
  parameter int MAX_VERSION = MAX_VERSION_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       buffer_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] byte_tag,
  output logic       held_cr_is_field,
  output logic       verdict_valid,
  output logic       line_status,
  output logic       version_minor,
  output logic [3:0] method_length,
  output logic [7:0] path_length
);

  localparam int MW = $clog2(MAX_METHOD + 1);
  localparam int PW = $clog2(MAX_PATH + 1);
  localparam int VW = $clog2(MAX_VERSION + 1);

  localparam logic [MW-1:0] MCAP = MW'(MAX_METHOD);
  localparam logic [PW-1:0] PCAP = PW'(MAX_PATH);
  localparam logic [VW-1:0] VCAP = VW'(MAX_VERSION);

  typedef struct packed {
    phase_t        phase;
    logic [MW-1:0] mcnt;
    logic [PW-1:0] pcnt;
    logic [VW-1:0] vidx;
    logic          minor;
    logic          ok;
    logic          crp;
    logic          given;
  } st_t;

  localparam st_t ST_RESET = '{phase: PH_METHOD, mcnt: '0, pcnt: '0, vidx: '0,
                               minor: 1'b0, ok: 1'b1, crp: 1'b0, given: 1'b0};

  function automatic st_t take(input st_t s, input logic [7:0] b);
    st_t r;
    r = s;
    case (s.phase)
      PH_METHOD: begin
        if (b < CH_UPPER_A || b > CH_UPPER_Z) r.ok = 1'b0;
        if (s.mcnt < MCAP) r.mcnt = s.mcnt + MW'(1);
        if (r.mcnt == MCAP) r.ok = 1'b0;
      end
      PH_PATH: begin
        if (s.pcnt == '0 && b != CH_SLASH) r.ok = 1'b0;
        if (s.pcnt < PCAP) r.pcnt = s.pcnt + PW'(1);
        if (r.pcnt == PCAP) r.ok = 1'b0;
      end
      default: begin
        if (s.vidx < VW'(7)) begin
          if (b != ver_prefix(s.vidx[2:0])) r.ok = 1'b0;
        end else if (s.vidx == VW'(7)) begin
          if (b == CH_ONE) r.minor = 1'b1;
          else if (b != CH_ZERO) r.ok = 1'b0;
        end else begin
          r.ok = 1'b0;
        end
        if (s.vidx < VCAP) r.vidx = s.vidx + VW'(1);
      end
    endcase
    return r;
  endfunction

  st_t  st;
  st_t  st_next;
  tag_t tag_next;
  logic held_next;
  logic vv_next;
  logic status_next;
  logic minor_next;
  logic crlf_hit;
  logic accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    st_next     = st;
    tag_next    = TAG_IGNORED;
    held_next   = 1'b0;
    vv_next     = 1'b0;
    status_next = 1'b0;
    minor_next  = 1'b0;
    crlf_hit    = 1'b0;
    if (!st.given) begin
      if (st.crp) begin
        st_next.crp = 1'b0;
        if (data_byte == CH_LF) begin
          crlf_hit      = 1'b1;
          tag_next      = TAG_SEP;
          vv_next       = 1'b1;
          st_next.given = 1'b1;
          if (st.ok && st.phase == PH_VERSION && st.vidx == VW'(8)) begin
            minor_next = st.minor;
          end else begin
            status_next = 1'b1;
          end
        end else begin
          held_next = 1'b1;
          st_next   = take(st_next, CH_CR);
        end
      end
      if (!crlf_hit) begin
        if (data_byte == CH_CR) begin
          st_next.crp = 1'b1;
          tag_next    = TAG_SEP;
        end else if (data_byte == CH_SP && st_next.phase == PH_METHOD) begin
          if (st_next.mcnt == '0) st_next.ok = 1'b0;
          st_next.phase = PH_PATH;
          tag_next      = TAG_SEP;
        end else if (data_byte == CH_SP && st_next.phase == PH_PATH) begin
          if (st_next.pcnt == '0) st_next.ok = 1'b0;
          st_next.phase = PH_VERSION;
          tag_next      = TAG_SEP;
        end else begin
          case (st_next.phase)
            PH_METHOD: tag_next = TAG_METHOD;
            PH_PATH:   tag_next = TAG_PATH;
            default:   tag_next = TAG_VERSION;
          endcase
          st_next = take(st_next, data_byte);
        end
      end
      if (buffer_end && !vv_next) begin
        vv_next     = 1'b1;
        status_next = 1'b1;
        minor_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_RESET;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        st        <= buffer_end ? ST_RESET : st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_tag         <= tag_next;
      held_cr_is_field <= held_next;
      verdict_valid    <= vv_next;
      line_status      <= status_next;
      version_minor    <= minor_next;
      method_length    <= (32'(st_next.mcnt) > 15) ? 4'hF : 4'(st_next.mcnt);
      path_length      <= (32'(st_next.pcnt) > 255) ? 8'hFF : 8'(st_next.pcnt);
    end
  end

endmodule

// ===== hdl/hrlc_checker.sv =====
// ----------------------------------------------------------------------------
// hrlc_checker
// Port-level checks of the request line checker, bound to the top level.
// ----------------------------------------------------------------------------
module hrlc_checker
  import hrlc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] byte_tag,
  input logic       held_cr_is_field,
  input logic       verdict_valid,
  input logic       line_status,
  input logic       version_minor,
  input logic [3:0] method_length,
  input logic [7:0] path_length
);

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_tag)
      && $stable(held_cr_is_field) && $stable(verdict_valid)
      && $stable(line_status) && $stable(version_minor)
      && $stable(method_length) && $stable(path_length))
    else $error("result word changed while stalled");

  a_status_needs_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_status |-> verdict_valid)
    else $error("malformed status without verdict");

  a_minor_needs_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && version_minor |-> verdict_valid && !line_status)
    else $error("version minor outside an accepted verdict");

  // an accepted line is only settled on the line feed
  a_accept_on_line_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict_valid && !line_status |-> byte_tag == TAG_SEP)
    else $error("accepted verdict on a non-separator word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind http_request_line_check_core hrlc_checker u_hrlc_checker (.*);
